### rtl/crc32_wrv_pkg.sv
// package for the crc-32 write/readback verifier: types, constants, crc update
package crc32_wrv_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_RESTART  = 2'd0,
        OP_WRITE    = 2'd1,
        OP_READBACK = 2'd2,
        OP_VERIFY   = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       read_error;
    } in_item_t;

    typedef struct packed {
        logic [31:0] write_crc_value;
        logic [31:0] write_byte_count;
        logic        verify_done;
        logic        verify_ok;
    } out_item_t;

    // one byte through the reflected crc-32, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, byte_in};
        for (int i = 0; i < 8; i++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic count_t count_up(input count_t count);
        return (count == COUNT_MAX) ? count : count + count_t'(1);
    endfunction

endpackage

### rtl/crc32_write_readback_verifier.sv
// top level of the crc-32 write/readback verifier
// Takes one item per clock while in_ready is high and gives exactly one
// result item for each. An accepted item sits in an input register, where
// the byte-wide crc-32 update, the saturating counters and the verify
// compare run, until the output queue has room; its result is then written
// from there into a two-entry output queue, whose count drives out_valid.
// The queue lets a new item be taken while one result waits; with out_ready
// held high the sustained rate is one item per cycle, and in_ready falls
// only when both queue entries hold untaken results and the input register
// holds a third item. Restart clears both accumulators, verify clears only
// the readback accumulator.
module crc32_write_readback_verifier
    import crc32_wrv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;

    logic [31:0] write_crc_reg,   write_crc_next;
    count_t      written_cnt_reg, written_cnt_next;
    logic [31:0] check_crc_reg,   check_crc_next;
    count_t      check_cnt_reg,   check_cnt_next;

    out_item_t   q_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  q_cnt_reg,  q_cnt_next;

    logic        advance;
    logic        pop;
    out_item_t   result;

    assign advance  = in_valid_reg && (q_cnt_reg != 2'd2);
    assign in_ready = !in_valid_reg || advance;
    assign pop      = out_valid && out_ready;

    assign out_valid = (q_cnt_reg != 2'd0);
    assign out_item  = q_reg[rd_ptr_reg];

    // accumulator update for the item in the input register
    always_comb
    begin
        logic ok;
        write_crc_next   = write_crc_reg;
        written_cnt_next = written_cnt_reg;
        check_crc_next   = check_crc_reg;
        check_cnt_next   = check_cnt_reg;
        ok               = 1'b0;
        unique case (in_item_reg.op)
            OP_RESTART:
            begin
                write_crc_next   = CRC_ONES;
                written_cnt_next = '0;
                check_crc_next   = CRC_ONES;
                check_cnt_next   = '0;
            end
            OP_WRITE:
            begin
                write_crc_next   = crc_byte(write_crc_reg, in_item_reg.data_byte);
                written_cnt_next = count_up(written_cnt_reg);
            end
            OP_READBACK:
            begin
                check_crc_next = crc_byte(check_crc_reg, in_item_reg.data_byte);
                check_cnt_next = count_up(check_cnt_reg);
            end
            OP_VERIFY:
            begin
                ok = (check_cnt_reg == written_cnt_reg)
                     && (check_crc_reg == write_crc_reg)
                     && !in_item_reg.read_error;
                check_crc_next = CRC_ONES;
                check_cnt_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        result.write_crc_value  = write_crc_next ^ CRC_ONES;
        result.write_byte_count = 32'(written_cnt_next);
        result.verify_done      = (in_item_reg.op == OP_VERIFY);
        result.verify_ok        = ok;
    end

    always_comb
    begin
        rd_ptr_next = pop     ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = advance ? !wr_ptr_reg : wr_ptr_reg;
        q_cnt_next  = q_cnt_reg + {1'b0, advance} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            write_crc_reg   <= CRC_ONES;
            written_cnt_reg <= '0;
            check_crc_reg   <= CRC_ONES;
            check_cnt_reg   <= '0;
            rd_ptr_reg      <= 1'b0;
            wr_ptr_reg      <= 1'b0;
            q_cnt_reg       <= 2'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                write_crc_reg   <= write_crc_next;
                written_cnt_reg <= written_cnt_next;
                check_crc_reg   <= check_crc_next;
                check_cnt_reg   <= check_cnt_next;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            q_reg[wr_ptr_reg] <= result;
        end
    end

endmodule

### bench/tb_crc32_write_readback_verifier.sv
// testbench for the crc-32 write/readback verifier: stimulus, result prediction and checking
`timescale 1ns / 1ps

module tb_crc32_write_readback_verifier;
    import crc32_wrv_pkg::*;

    localparam logic [31:0] REFL_POLY = 32'hEDB88320;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    crc32_write_readback_verifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #2 clk = ~clk;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned error_count    = 0;
    int unsigned verify_passes  = 0;
    int unsigned verify_fails   = 0;

    out_item_t expected_results[$];

    // predictor copy of the two accumulators
    logic [31:0] wr_crc   = '1;
    count_t      wr_count = '0;
    logic [31:0] rb_crc   = '1;
    count_t      rb_count = '0;

    function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] acc;
        logic        fb;
        acc = c;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ REFL_POLY;
        end
        return acc;
    endfunction

    function automatic count_t count_bump(input count_t c);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, c} + 1'b1;
        return sum[COUNT_WIDTH] ? c : sum[COUNT_WIDTH-1:0];
    endfunction

    // predict the result of every accepted item
    always @(posedge clk) begin : predict_result
        out_item_t r;
        if (rst_n && in_valid && in_ready) begin
            r = '0;
            case (in_item.op)
                OP_RESTART: begin
                    wr_crc   = '1;
                    wr_count = '0;
                    rb_crc   = '1;
                    rb_count = '0;
                end
                OP_WRITE: begin
                    wr_crc   = crc32_shift(wr_crc, in_item.data_byte);
                    wr_count = count_bump(wr_count);
                end
                OP_READBACK: begin
                    rb_crc   = crc32_shift(rb_crc, in_item.data_byte);
                    rb_count = count_bump(rb_count);
                end
                OP_VERIFY: begin
                    r.verify_done = 1'b1;
                    r.verify_ok   = (rb_count == wr_count) && (rb_crc == wr_crc)
                                    && !in_item.read_error;
                    rb_crc   = '1;
                    rb_count = '0;
                end
                default: ;
            endcase
            r.write_crc_value  = ~wr_crc;
            r.write_byte_count = wr_count[31:0];
            expected_results.push_back(r);
        end
    end

    always @(posedge clk) begin : check_result
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("error: result item with nothing expected: crc %h count %0d",
                             out_item.write_crc_value, out_item.write_byte_count);
            end else begin
                want = expected_results.pop_front();
                if (out_item.verify_done)
                    if (out_item.verify_ok) verify_passes++;
                    else verify_fails++;
                if (out_item.write_crc_value !== want.write_crc_value
                    || out_item.write_byte_count !== want.write_byte_count
                    || out_item.verify_done !== want.verify_done
                    || out_item.verify_ok !== want.verify_ok) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: crc exp %h got %h, count exp %0d got %0d, ",
                                  "done exp %b got %b, ok exp %b got %b"},
                                 want.write_crc_value, out_item.write_crc_value,
                                 want.write_byte_count, out_item.write_byte_count,
                                 want.verify_done, out_item.verify_done,
                                 want.verify_ok, out_item.verify_ok);
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_item(input op_t op, input logic [7:0] b, input logic err);
        in_item_t item;
        item.op         = op;
        item.data_byte  = b;
        item.read_error = err;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_directed();
        // restart and verify ignore data and, for restart, the error bit
        send_item(OP_RESTART, 8'hFF, 1'b1);
        send_item(OP_VERIFY, 8'h00, 1'b0);    // empty against empty passes
        send_item(OP_VERIFY, 8'hFF, 1'b1);    // read error forces failure
        send_item(OP_WRITE, 8'h00, 1'b1);
        send_item(OP_WRITE, 8'hFF, 1'b0);
        send_item(OP_WRITE, 8'hA5, 1'b0);
        send_item(OP_READBACK, 8'h00, 1'b1);
        send_item(OP_READBACK, 8'hFF, 1'b0);
        send_item(OP_READBACK, 8'hA5, 1'b0);
        send_item(OP_VERIFY, 8'h5A, 1'b0);    // match
        send_item(OP_READBACK, 8'h00, 1'b0);
        send_item(OP_READBACK, 8'hFF, 1'b0);
        send_item(OP_VERIFY, 8'h00, 1'b0);    // short readback
        send_item(OP_READBACK, 8'h00, 1'b0);
        send_item(OP_READBACK, 8'hFF, 1'b0);
        send_item(OP_READBACK, 8'h5A, 1'b0);
        send_item(OP_VERIFY, 8'h00, 1'b0);    // same length, wrong data
        send_item(OP_READBACK, 8'h00, 1'b0);
        send_item(OP_READBACK, 8'hFF, 1'b0);
        send_item(OP_READBACK, 8'hA5, 1'b0);
        send_item(OP_VERIFY, 8'h00, 1'b1);    // good data but read error
        send_item(OP_VERIFY, 8'h00, 1'b0);    // check side was cleared by verify
        send_item(OP_RESTART, 8'h00, 1'b0);
        send_item(OP_READBACK, 8'h12, 1'b0);  // readback with no writes
        send_item(OP_VERIFY, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        send_item(OP_RESTART, 8'h00, 1'b0);
        for (int i = 0; i < 4; i++)
            send_item(OP_WRITE, 8'(8'h30 + i), 1'b0);
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_item(OP_READBACK, 8'(8'h30 + i), 1'b0);
        wait_drained();
        send_item(OP_VERIFY, 8'h00, 1'b0);
        wait_drained();
    endtask

    // mostly write / readback / verify sequences, some corrupted, plus random noise
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_items);
        logic [7:0]  history[$];
        logic [7:0]  readback[$];
        logic [7:0]  b;
        logic        err;
        logic        need_restart;
        int unsigned stop_at;
        int unsigned idx;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at        = items_sent + n_items;
        need_restart   = 1'b1;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                if (need_restart || history.size() > 24 || $urandom_range(2) == 0) begin
                    send_item(OP_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    history.delete();
                    need_restart = 1'b0;
                end
                repeat ($urandom_range(10)) begin
                    b = 8'($urandom_range(255));
                    history.push_back(b);
                    send_item(OP_WRITE, b, 1'($urandom_range(1)));
                end
                repeat ($urandom_range(1, 2)) begin
                    readback = history;
                    err = 1'b0;
                    case ($urandom_range(9))
                        0: if (readback.size() > 0) begin
                            idx = $urandom_range(readback.size() - 1);
                            readback[idx] = readback[idx] ^ (8'h01 << $urandom_range(7));
                        end
                        1: if (readback.size() > 0) void'(readback.pop_back());
                        2: readback.push_back(8'($urandom_range(255)));
                        3: err = 1'b1;
                        default: ;
                    endcase
                    foreach (readback[i])
                        send_item(OP_READBACK, readback[i], 1'($urandom_range(1)));
                    send_item(OP_VERIFY, 8'($urandom_range(255)), err);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                need_restart = 1'b1;
            end
        end
        wait_drained();
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 26;
        recv_stall_pct = 59;
        test_directed();
        test_pause_until_drained();
        test_random_traffic(26, 59, 150);
        test_random_traffic(59, 26, 150);
        test_random_traffic(0, 0, 150);

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("error: %0d expected result items never arrived",
                     expected_results.size());
        end
        $display("sent %0d items over three idling profiles", items_sent);
        $display("saw %0d passing and %0d failing verifies", verify_passes, verify_fails);
        $display("errors: %0d", error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### crc32_write_readback_verifier.f
rtl/crc32_wrv_pkg.sv
rtl/crc32_write_readback_verifier.sv
bench/tb_crc32_write_readback_verifier.sv
